// ===== src/srpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_pkg
// shared types and constants for the ring pointer manager
// ----------------------------------------------------------------------------
package srpm_pkg;

  localparam int AREA_WIDTH_DEF  = 2048;
  localparam int AREA_HEIGHT_DEF = 2048;
  localparam int SCAN_DEPTH_DEF  = 4096;
  localparam int LINE_DEPTH_DEF  = 2048;

  localparam int XW = 11;
  localparam int AW = 22;
  localparam int SW = 12;
  localparam int LW = 11;

  typedef enum logic [3:0] {
    FN_BEGIN_DATA = 4'd0,
    FN_END_DATA   = 4'd1,
    FN_BEGIN_SCAN = 4'd2,
    FN_END_SCAN   = 4'd3,
    FN_ANNOUNCE   = 4'd4,
    FN_TAKE_AREA  = 4'd5,
    FN_COMPLETE   = 4'd6,
    FN_OWNER      = 4'd7,
    FN_ATTACH     = 4'd8
  } func_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [1:0] CFG_DUB  = 2'd0;
  localparam logic [1:0] CFG_SCAN = 2'd1;
  localparam logic [1:0] CFG_LINE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic div_start;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_div;
  } stat_t;

endpackage

// ===== src/scan_ring_pointer_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_ring_pointer_manager_unit
// producer/consumer pointer manager for a pixel area, a scan ring, a line ring
// ----------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; the in_ ports
//   carry the command and its operands
//   exactly one result follows each request, shown on the out_ ports for one
//   cycle with out_valid high; the receiver cannot hold it off
//   data grant, scan grant and announce run a 13-step restoring divider
//   (alignment pad or ring successor), then the execute state, which sets
//   out_valid through a register
//   every other command goes straight to the execute state; out_valid rises
//   as busy falls, so the next request can be taken while it is shown
//   busy stays high until the execute cycle has passed
//   configuration writes (cfg_we, cfg_index, cfg_data) are registered;
//   the user must make them only while the unit is idle, which the unit
//   does not enforce; synchronous active-low reset clears all pointers, flags
//   and the sequencer, and restores the ring size registers to full depth
// ----------------------------------------------------------------------------
module scan_ring_pointer_manager_unit
  import srpm_pkg::*;
#(
  parameter int AREA_WIDTH  = AREA_WIDTH_DEF,
  parameter int AREA_HEIGHT = AREA_HEIGHT_DEF,
  parameter int SCAN_DEPTH  = SCAN_DEPTH_DEF,
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [3:0]  in_func,
  input  logic [10:0] in_length,
  input  logic [10:0] in_alignment,
  input  logic        in_vretrace_end,
  input  logic        in_visible,
  input  logic [10:0] in_done_line,
  input  logic [11:0] in_done_scan,
  input  logic [10:0] in_done_x,
  input  logic [10:0] in_done_y,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [10:0] out_addr_x,
  output logic [10:0] out_addr_y,
  output logic [11:0] out_scan_slot,
  output logic [10:0] out_line_slot,
  output logic [11:0] out_first_scan,
  output logic        out_first_in_frame,
  output logic        out_prev_frame_complete,
  output logic        out_line_committed,
  output logic [10:0] out_end_line,
  output logic [11:0] out_end_scan,
  output logic [21:0] out_end_addr
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle, divide, execute
  srpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // pointer sets and result registers; area width sets the row wrap point
  srpm_datapath #(
    .AREA_WIDTH  (AREA_WIDTH),
    .AREA_HEIGHT (AREA_HEIGHT),
    .SCAN_DEPTH  (SCAN_DEPTH),
    .LINE_DEPTH  (LINE_DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .stat                    (stat),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_func                 (in_func),
    .in_length               (in_length),
    .in_alignment            (in_alignment),
    .in_vretrace_end         (in_vretrace_end),
    .in_visible              (in_visible),
    .in_done_line            (in_done_line),
    .in_done_scan            (in_done_scan),
    .in_done_x               (in_done_x),
    .in_done_y               (in_done_y),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_addr_x              (out_addr_x),
    .out_addr_y              (out_addr_y),
    .out_scan_slot           (out_scan_slot),
    .out_line_slot           (out_line_slot),
    .out_first_scan          (out_first_scan),
    .out_first_in_frame      (out_first_in_frame),
    .out_prev_frame_complete (out_prev_frame_complete),
    .out_line_committed      (out_line_committed),
    .out_end_line            (out_end_line),
    .out_end_scan            (out_end_scan),
    .out_end_addr            (out_end_addr)
  );

endmodule

// ===== src/srpm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_ctrl
// sequencer: waits for a request, runs the divider when needed, executes
// ----------------------------------------------------------------------------
module srpm_ctrl
  import srpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.div_start = 1'b0;
    cmd.exec      = 1'b0;
    busy          = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.div_start = 1'b1;
          state_nxt     = stat.need_div ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/srpm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_datapath
// pointer sets, shared remainder divider and command execution
// ----------------------------------------------------------------------------
module srpm_datapath
  import srpm_pkg::*;
#(
  parameter int AREA_WIDTH  = AREA_WIDTH_DEF,
  parameter int AREA_HEIGHT = AREA_HEIGHT_DEF,
  parameter int SCAN_DEPTH  = SCAN_DEPTH_DEF,
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output stat_t         stat,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  input  logic [3:0]    in_func,
  input  logic [10:0]   in_length,
  input  logic [10:0]   in_alignment,
  input  logic          in_vretrace_end,
  input  logic          in_visible,
  input  logic [10:0]   in_done_line,
  input  logic [11:0]   in_done_scan,
  input  logic [10:0]   in_done_x,
  input  logic [10:0]   in_done_y,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [10:0]   out_addr_x,
  output logic [10:0]   out_addr_y,
  output logic [11:0]   out_scan_slot,
  output logic [10:0]   out_line_slot,
  output logic [11:0]   out_first_scan,
  output logic          out_first_in_frame,
  output logic          out_prev_frame_complete,
  output logic          out_line_committed,
  output logic [10:0]   out_end_line,
  output logic [11:0]   out_end_scan,
  output logic [21:0]   out_end_addr
);

  localparam int SCAN_CAP = (SCAN_DEPTH < 4096) ? SCAN_DEPTH : 4096;
  localparam int LINE_CAP = (LINE_DEPTH < 2048) ? LINE_DEPTH : 2048;
  localparam logic [22:0] AREA_MOD  = 23'(AREA_HEIGHT) << XW;
  localparam logic [12:0] AREA_SPAN = 13'(AREA_WIDTH);

  // configuration
  logic [2:0]  dub_r;
  logic [12:0] ssz_cfg_r;
  logic [11:0] lsz_cfg_r;

  // latched request
  logic [3:0]  func_r;
  logic [10:0] len_r, aln_r;
  logic        vret_r, vis_r;
  logic [10:0] dline_r, dx_r, dy_r;
  logic [11:0] dscan_r;

  // pointer state
  logic [21:0] wr_area_r, sub_area_r, rd_area_r, ah_area_r, vend_r;
  logic [11:0] wr_scan_r, sub_scan_r, rd_scan_r, ah_scan_r;
  logic [10:0] wr_line_r, sub_line_r, rd_line_r, ah_line_r;
  logic        fail_r, dpend_r, spend_r, vis_out_r, attached_r;
  logic [12:0] sol_r;
  logic        ff_first_r, ff_comp_r, ff_prev_r;

  // effective ring sizes
  logic [12:0] ssz;
  logic [11:0] lsz;
  always_comb begin
    ssz = (ssz_cfg_r < 13'd2) ? 13'd2 : ssz_cfg_r;
    if (ssz > 13'(SCAN_CAP)) ssz = 13'(SCAN_CAP);
    lsz = (lsz_cfg_r < 12'd2) ? 12'd2 : lsz_cfg_r;
    if (lsz > 12'(LINE_CAP)) lsz = 12'(LINE_CAP);
  end

  // restoring divider, remainder only: alignment pad, next scan, next line
  logic [12:0] div_rem_r;
  logic [12:0] div_num_r;
  logic [12:0] div_den_r;
  logic [3:0]  div_cnt_r;
  logic        div_run_r;
  logic [10:0] aln_eff;
  logic [12:0] div_num_in, div_den_in;
  logic [12:0] rem_shift;

  assign aln_eff       = (in_alignment == 11'd0) ? 11'd1 : in_alignment;
  assign stat.need_div = (in_func == FN_BEGIN_DATA) || (in_func == FN_BEGIN_SCAN) ||
                         (in_func == FN_ANNOUNCE);
  assign stat.div_done = div_run_r && (div_cnt_r == 4'd0);
  assign rem_shift     = {div_rem_r[11:0], div_num_r[12]};

  // operands picked by the request being taken
  always_comb begin
    if (in_func == FN_BEGIN_SCAN) begin
      div_num_in = 13'(wr_scan_r) + 13'd1;
      div_den_in = ssz;
    end else if (in_func == FN_ANNOUNCE) begin
      div_num_in = 13'(wr_line_r) + 13'd1;
      div_den_in = 13'(lsz);
    end else begin
      div_num_in = 13'(wr_area_r[10:0]) + 13'd1;
      div_den_in = 13'(aln_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_run_r <= stat.need_div;
      div_cnt_r <= 4'd13;
      div_rem_r <= '0;
      div_num_r <= div_num_in;
      div_den_r <= div_den_in;
    end else if (div_run_r && div_cnt_r != 4'd0) begin
      div_cnt_r <= div_cnt_r - 4'd1;
      div_num_r <= {div_num_r[11:0], 1'b0};
      if (rem_shift >= div_den_r) begin
        div_rem_r <= rem_shift - div_den_r;
      end else begin
        div_rem_r <= rem_shift;
      end
    end else if (cmd.exec) begin
      div_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      func_r  <= in_func;
      len_r   <= in_length;
      aln_r   <= aln_eff;
      vret_r  <= in_vretrace_end;
      vis_r   <= in_visible;
      dline_r <= in_done_line;
      dscan_r <= in_done_scan;
      dx_r    <= in_done_x;
      dy_r    <= in_done_y;
    end
  end

  // data grant arithmetic
  logic [12:0] bd_s, bd_e;
  logic [10:0] bd_y;
  logic [21:0] bd_end, bd_dend, bd_dprev, bd_wr;
  logic        bd_ok;
  logic [11:0] pad;
  always_comb begin
    pad  = (div_rem_r == 13'd0) ? 12'd0 : 12'(aln_r) - div_rem_r[11:0];
    bd_y = wr_area_r[21:11];
    bd_s = 13'(wr_area_r[10:0]) + 13'd1 + 13'(pad);
    bd_e = bd_s + 13'd1 + 13'(len_r);
    if (bd_e > AREA_SPAN) begin
      bd_y = (12'(bd_y) + 12'd1 >= 12'(AREA_HEIGHT)) ? 11'd0 : bd_y + 11'd1;
      bd_s = 13'(aln_r);
      bd_e = bd_s + 13'd1 + 13'(len_r);
    end
    bd_end   = 22'({bd_y, 11'd0} + 23'(bd_e));
    bd_wr    = 22'({bd_y, 11'd0} + 23'(bd_s));
    bd_dend  = bd_end - rd_area_r;
    bd_dprev = wr_area_r - rd_area_r;
    bd_ok    = !(bd_dend < bd_dprev);
  end

  // data run advance
  logic [22:0] ed_sum;
  assign ed_sum = 23'(wr_area_r) + 23'(len_r) + 23'd1;

  // ring successors, taken from the divider remainder
  logic [11:0] scan_next;
  logic [10:0] line_next;
  assign scan_next = div_rem_r[11:0];
  assign line_next = div_rem_r[10:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dub_r <= '0; ssz_cfg_r <= 13'd4096; lsz_cfg_r <= 12'd2048;
      wr_area_r <= '0; wr_scan_r <= '0; wr_line_r <= '0;
      sub_area_r <= '0; sub_scan_r <= '0; sub_line_r <= '0;
      rd_area_r <= '0; rd_scan_r <= '0; rd_line_r <= '0;
      ah_area_r <= '0; ah_scan_r <= '0; ah_line_r <= '0;
      fail_r <= 1'b0; dpend_r <= 1'b0; spend_r <= 1'b0;
      vis_out_r <= 1'b0; attached_r <= 1'b0; vend_r <= '0; sol_r <= '0;
      ff_first_r <= 1'b0; ff_comp_r <= 1'b0; ff_prev_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DUB:  dub_r <= cfg_data[2:0];
          CFG_SCAN: ssz_cfg_r <= cfg_data;
          CFG_LINE: lsz_cfg_r <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        out_status <= ST_IGNORED;
        out_addr_x <= '0; out_addr_y <= '0; out_scan_slot <= '0;
        out_line_slot <= '0; out_first_scan <= '0; out_first_in_frame <= 1'b0;
        out_prev_frame_complete <= 1'b0; out_line_committed <= 1'b0;
        out_end_line <= '0; out_end_scan <= '0; out_end_addr <= '0;
        unique case (func_r)
          FN_BEGIN_DATA: begin
            out_status <= ST_FAIL;
            if (!fail_r) begin
              if (!attached_r || dub_r == 3'd0 || !bd_ok) begin
                fail_r <= 1'b1;
              end else begin
                out_status <= ST_OK;
                dpend_r    <= 1'b1;
                wr_area_r  <= bd_wr;
                vend_r     <= bd_wr;
                out_addr_x <= bd_wr[10:0];
                out_addr_y <= bd_wr[21:11];
              end
            end
          end
          FN_END_DATA: begin
            if (dpend_r) begin
              dpend_r    <= 1'b0;
              out_addr_x <= vend_r[10:0];
              out_addr_y <= vend_r[21:11];
              if (fail_r) begin
                out_status <= ST_FAIL;
              end else begin
                out_status <= ST_OK;
                wr_area_r  <= (ed_sum >= AREA_MOD) ? 22'(ed_sum - AREA_MOD) : ed_sum[21:0];
              end
            end
          end
          FN_BEGIN_SCAN: begin
            out_status <= ST_FAIL;
            if (fail_r) begin
              spend_r <= 1'b0;
            end else if (scan_next == rd_scan_r) begin
              fail_r <= 1'b1; spend_r <= 1'b0;
            end else begin
              out_status    <= ST_OK;
              out_scan_slot <= wr_scan_r;
              out_line_slot <= wr_line_r;
              wr_scan_r     <= scan_next;
              if (sol_r != 13'h1fff) sol_r <= sol_r + 13'd1;
              spend_r       <= 1'b1;
            end
          end
          FN_END_SCAN: begin
            if (spend_r) begin
              spend_r       <= 1'b0;
              out_addr_x    <= vend_r[10:0];
              out_addr_y    <= vend_r[21:11];
              out_line_slot <= wr_line_r;
              out_status    <= ST_OK;
            end
          end
          FN_ANNOUNCE: begin
            if (vret_r) begin
              ff_first_r <= 1'b1; ff_prev_r <= ff_comp_r; ff_comp_r <= 1'b1;
            end
            if (vis_out_r != vis_r) begin
              vis_out_r     <= vis_r;
              out_line_slot <= wr_line_r;
              if (vis_r) begin
                fail_r <= (line_next == rd_line_r);
                if (line_next == rd_line_r) begin
                  out_status <= ST_FAIL;
                end else begin
                  out_status <= ST_OK;
                  sol_r      <= '0;
                end
              end else if (!fail_r && sol_r != 13'd0) begin
                out_status              <= ST_OK;
                out_first_scan          <= sub_scan_r;
                out_first_in_frame      <= vret_r | ff_first_r;
                out_prev_frame_complete <= vret_r ? ff_comp_r : ff_prev_r;
                out_line_committed      <= 1'b1;
                ff_first_r              <= 1'b0;
                wr_line_r  <= line_next;
                sub_line_r <= line_next;
                sub_scan_r <= wr_scan_r;
                sub_area_r <= wr_area_r;
              end else begin
                wr_area_r <= sub_area_r; wr_scan_r <= sub_scan_r;
                wr_line_r <= sub_line_r;
                if (fail_r) begin
                  ff_comp_r  <= 1'b0;
                  out_status <= ST_FAIL;
                end else begin
                  out_status <= ST_OK;
                end
              end
            end
          end
          FN_TAKE_AREA: begin
            out_status    <= ST_OK;
            out_addr_x    <= ah_area_r[10:0];
            out_addr_y    <= ah_area_r[21:11];
            out_scan_slot <= ah_scan_r;
            out_line_slot <= ah_line_r;
            out_end_line  <= sub_line_r;
            out_end_scan  <= sub_scan_r;
            out_end_addr  <= sub_area_r;
            ah_area_r <= sub_area_r; ah_scan_r <= sub_scan_r; ah_line_r <= sub_line_r;
          end
          FN_COMPLETE: begin
            out_status <= ST_OK;
            rd_line_r  <= dline_r;
            rd_scan_r  <= dscan_r;
            rd_area_r  <= {dy_r, dx_r};
          end
          FN_OWNER: begin
            out_status <= ST_OK;
            fail_r <= 1'b1; spend_r <= 1'b0;
          end
          FN_ATTACH: begin
            out_status <= ST_OK;
            attached_r <= 1'b1;
            wr_area_r <= '0; wr_scan_r <= '0; wr_line_r <= '0;
            sub_area_r <= '0; sub_scan_r <= '0; sub_line_r <= '0;
            rd_area_r <= '0; rd_scan_r <= '0; rd_line_r <= '0;
            fail_r <= 1'b1; spend_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
